/* src/mlon_pkg.sv */
// ----------------------------------------------------------------------------
// mlon_pkg
// Shared types and codes of the mask lattice and outline node selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlon_pkg;

    localparam int CFG_W        = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int CELL_INDEX_W = 20;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LATTICE_STEP = 2'd2;

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // bit positions inside one column of the 3x3 window
    localparam int TRI_TOP = 0;
    localparam int TRI_MID = 1;
    localparam int TRI_BOT = 2;

    typedef struct packed {
        logic                    emit;
        logic                    shift;
        logic                    decide;
        logic                    lattice;
        logic                    done;
        logic                    top_ok;
        logic                    bot_ok;
        logic                    left_ok;
        logic                    right_ok;
        logic [2:0]              cur;
        logic [CELL_INDEX_W-1:0] index;
    } token_t;

endpackage

/* src/mlon_front.sv */
// ----------------------------------------------------------------------------
// mlon_front
// Accepts items, tracks raster and decision positions, keeps the two-row
// column store and issues one classified token per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlon_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [mlon_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mlon_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic                             inside_req,
    input  logic                             q_full,
    output logic                             q_push,
    output mlon_pkg::token_t                 q_data
);
    import mlon_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    function automatic logic [CFG_W-1:0] phase_inc(input logic [CFG_W-1:0] p,
                                                   input logic [CFG_W-1:0] s);
        logic [CFG_W:0] n;
        n = {1'b0, p} + {{CFG_W{1'b0}}, 1'b1};
        return (n >= {1'b0, s}) ? '0 : n[CFG_W-1:0];
    endfunction

    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [CFG_W-1:0] step_cfg_reg;

    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [CFG_W-1:0] step_eff;

    logic [WW-1:0]    in_column_reg, in_column_next;
    logic [RW-1:0]    in_row_reg, in_row_next;
    logic [WW-1:0]    dcol_reg, dcol_next;
    logic [HW-1:0]    drow_reg, drow_next;
    logic [CFG_W-1:0] cph_reg, cph_next;
    logic [CFG_W-1:0] rph_reg, rph_next;
    logic [DW-1:0]    dcount_reg, dcount_next;
    logic             inject_reg, inject_next;

    logic             s1_valid_reg, s1_valid_next;
    token_t           s1_tok_reg;

    logic [1:0]       line_mem [MAX_WIDTH];
    logic [1:0]       rd_raw_reg;
    logic             fwd_reg;
    logic [1:0]       fwd_data_reg;
    logic             wr_en_reg;
    logic [AW-1:0]    wr_addr_reg;
    logic             wr_inside_reg;
    logic [1:0]       rd_word;
    logic [1:0]       wr_data;
    logic [AW-1:0]    rd_addr;

    logic   cfg_hit;
    logic   s1_free;
    logic   fire_in;
    logic   fire;
    logic   access;
    logic   adv;
    logic   dec;
    logic   set_inject;
    logic   row_past;
    logic   last_col;
    logic   d_last_col;
    logic   d_last_row;
    token_t tok;

    assign cfg_hit = cfg_write_en && (cfg_index == REG_FRAME_WIDTH ||
                                      cfg_index == REG_FRAME_HEIGHT ||
                                      cfg_index == REG_LATTICE_STEP);

    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_cfg_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(height_cfg_reg);
        end
        step_eff = (step_cfg_reg == '0) ? CFG_W'(1) : step_cfg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_W'(1024);
            height_cfg_reg <= CFG_W'(1024);
            step_cfg_reg   <= CFG_W'(1);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_cfg_reg <= cfg_data;
                REG_LATTICE_STEP: step_cfg_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign s1_free  = !s1_valid_reg || !q_full;
    assign in_ready = !inject_reg && s1_free;
    assign fire_in  = in_valid && in_ready;
    assign fire     = fire_in || (inject_reg && s1_free);

    assign row_past   = in_row_reg >= RW'(h_eff);
    assign last_col   = in_column_reg == w_eff - WW'(1);
    assign d_last_col = dcol_reg == w_eff - WW'(1);
    assign d_last_row = drow_reg == h_eff - HW'(1);

    // classify
    always_comb
    begin
        tok        = '0;
        access     = 1'b0;
        adv        = 1'b0;
        dec        = 1'b0;
        set_inject = 1'b0;
        if (inject_reg)
        begin
            access    = 1'b1;
            adv       = 1'b1;
            tok.shift = 1'b1;
        end
        else
        begin
            tok.emit = 1'b1;
            unique case (operation)
                OP_CELL:
                begin
                    if (!row_past)
                    begin
                        access   = 1'b1;
                        adv      = 1'b1;
                        tok.shift = 1'b1;
                        tok.cur[TRI_BOT] = inside_req;
                        dec = (in_row_reg >= RW'(2)) ||
                              (in_row_reg == RW'(1) && in_column_reg != '0);
                        set_inject = (h_eff == HW'(1)) && last_col;
                    end
                end
                OP_DRAIN:
                begin
                    if (row_past)
                    begin
                        access    = 1'b1;
                        adv       = 1'b1;
                        tok.shift = 1'b1;
                        dec       = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (dec)
        begin
            tok.decide   = 1'b1;
            tok.lattice  = (cph_reg == '0 || d_last_col) && (rph_reg == '0 || d_last_row);
            tok.done     = d_last_col && d_last_row;
            tok.top_ok   = drow_reg != '0;
            tok.bot_ok   = !d_last_row;
            tok.left_ok  = dcol_reg != '0;
            tok.right_ok = !d_last_col;
            tok.index    = CELL_INDEX_W'(dcount_reg);
        end
    end

    always_comb
    begin
        in_column_next = in_column_reg;
        in_row_next    = in_row_reg;
        dcol_next      = dcol_reg;
        drow_next      = drow_reg;
        cph_next       = cph_reg;
        rph_next       = rph_reg;
        dcount_next    = dcount_reg;
        inject_next    = inject_reg;
        if (cfg_hit || (fire && dec && tok.done))
        begin
            in_column_next = '0;
            in_row_next    = '0;
            dcol_next      = '0;
            drow_next      = '0;
            cph_next       = '0;
            rph_next       = '0;
            dcount_next    = '0;
            inject_next    = 1'b0;
        end
        else if (fire)
        begin
            inject_next = set_inject;
            if (adv)
            begin
                if (last_col)
                begin
                    in_column_next = '0;
                    in_row_next    = in_row_reg + RW'(1);
                end
                else
                begin
                    in_column_next = in_column_reg + WW'(1);
                end
            end
            if (dec)
            begin
                dcount_next = dcount_reg + DW'(1);
                if (d_last_col)
                begin
                    dcol_next = '0;
                    cph_next  = '0;
                    drow_next = drow_reg + HW'(1);
                    rph_next  = phase_inc(rph_reg, step_eff);
                end
                else
                begin
                    dcol_next = dcol_reg + WW'(1);
                    cph_next  = phase_inc(cph_reg, step_eff);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg <= '0;
            in_row_reg    <= '0;
            dcol_reg      <= '0;
            drow_reg      <= '0;
            cph_reg       <= '0;
            rph_reg       <= '0;
            dcount_reg    <= '0;
            inject_reg    <= 1'b0;
        end
        else
        begin
            in_column_reg <= in_column_next;
            in_row_reg    <= in_row_next;
            dcol_reg      <= dcol_next;
            drow_reg      <= drow_next;
            cph_reg       <= cph_next;
            rph_reg       <= rph_next;
            dcount_reg    <= dcount_next;
            inject_reg    <= inject_next;
        end
    end

    // column store: word[1] = previous row, word[0] = the row before it
    assign rd_addr = in_column_reg[AW-1:0];
    assign rd_word = fwd_reg ? fwd_data_reg : rd_raw_reg;
    assign wr_data = {wr_inside_reg, rd_word[1]};

    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            line_mem[wr_addr_reg] <= wr_data;
        end
        if (fire && access)
        begin
            rd_raw_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && access)
        begin
            fwd_data_reg  <= wr_data;
            wr_addr_reg   <= rd_addr;
            wr_inside_reg <= tok.cur[TRI_BOT];
        end
        if (fire)
        begin
            s1_tok_reg <= tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_en_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            wr_en_reg <= fire && access;
            if (fire && access)
            begin
                fwd_reg <= wr_en_reg && (wr_addr_reg == rd_addr);
            end
        end
    end

    assign q_push = s1_valid_reg && !q_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_comb
    begin
        q_data = s1_tok_reg;
        q_data.cur[TRI_TOP] = rd_word[0];
        q_data.cur[TRI_MID] = rd_word[1];
    end

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (in_row_reg == '0 && dcount_reg == '0 && !inject_reg))
        else $error("config write did not restart the frame");

    a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && dec && tok.done) |=> (in_row_reg == '0 && in_column_reg == '0))
        else $error("frame end did not clear the raster position");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_column_reg < w_eff) && (dcol_reg < w_eff))
        else $error("column counter beyond frame width");

endmodule

/* src/mlon_queue.sv */
// ----------------------------------------------------------------------------
// mlon_queue
// Short token queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlon_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mlon_pkg::token_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output mlon_pkg::token_t pop_data
);
    import mlon_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    token_t        entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = count_reg == CW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("token queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("token queue underflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("token queue count out of range");

endmodule

/* src/mlon_back.sv */
// ----------------------------------------------------------------------------
// mlon_back
// Holds the 3x3 window columns, decides node status and drives the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlon_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  mlon_pkg::token_t                  q_data,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              decided,
    output logic                              is_node,
    output logic [mlon_pkg::CELL_INDEX_W-1:0] cell_index,
    output logic                              frame_done
);
    import mlon_pkg::*;

    logic [2:0] s0_reg;
    logic [2:0] s1_reg;
    logic       out_valid_reg, out_valid_next;
    logic       decided_reg;
    logic       is_node_reg;
    logic       frame_done_reg;
    logic [CELL_INDEX_W-1:0] cell_index_reg;

    logic [2:0] col_l;
    logic [2:0] col_c;
    logic [2:0] col_r;
    logic       outline;
    logic       node;

    assign col_l = s1_reg;
    assign col_c = s0_reg;
    assign col_r = q_data.cur;

    // any in-bounds neighbour outside the region
    always_comb
    begin
        outline = (q_data.top_ok && q_data.left_ok  && !col_l[TRI_TOP]) ||
                  (q_data.top_ok                    && !col_c[TRI_TOP]) ||
                  (q_data.top_ok && q_data.right_ok && !col_r[TRI_TOP]) ||
                  (q_data.left_ok                   && !col_l[TRI_MID]) ||
                  (q_data.right_ok                  && !col_r[TRI_MID]) ||
                  (q_data.bot_ok && q_data.left_ok  && !col_l[TRI_BOT]) ||
                  (q_data.bot_ok                    && !col_c[TRI_BOT]) ||
                  (q_data.bot_ok && q_data.right_ok && !col_r[TRI_BOT]);
        node = col_c[TRI_MID] && (q_data.lattice || outline);
    end

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = q_data.emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            decided_reg    <= q_data.decide;
            is_node_reg    <= q_data.decide && node;
            frame_done_reg <= q_data.decide && q_data.done;
            cell_index_reg <= q_data.index;
            if (q_data.shift)
            begin
                s1_reg <= s0_reg;
                s0_reg <= col_r;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign decided    = decided_reg;
    assign is_node    = is_node_reg;
    assign frame_done = frame_done_reg;
    assign cell_index = cell_index_reg;

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_data.emit) |=> out_valid_reg)
        else $error("emitted token produced no result");

    a_done_decided: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_done_reg) |-> decided_reg)
        else $error("frame end without a decision");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(decided_reg) &&
            $stable(is_node_reg) && $stable(cell_index_reg) && $stable(frame_done_reg)))
        else $error("result item changed while waiting");

endmodule

/* src/mask_lattice_and_outline_nodes_top.sv */
// ----------------------------------------------------------------------------
// mask_lattice_and_outline_nodes_top
// One item per cycle while in_ready is high; results pass the front stage,
// queue and result register. A one-row frame's last cell adds a window-fill
// token. Reset clears all counters and loads width 1024, height 1024, step 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mask_lattice_and_outline_nodes_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [mlon_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mlon_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic                              inside_req,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              decided,
    output logic                              is_node,
    output logic [mlon_pkg::CELL_INDEX_W-1:0] cell_index,
    output logic                              frame_done
);
    import mlon_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    token_t push_tok;
    token_t pop_tok;

    mlon_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .inside_req   (inside_req),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (push_tok)
    );

    mlon_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_tok),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (pop_tok)
    );

    mlon_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (pop_tok),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .decided    (decided),
        .is_node    (is_node),
        .cell_index (cell_index),
        .frame_done (frame_done)
    );

endmodule

/* tb/mask_lattice_and_outline_nodes_checker.sv */
// ----------------------------------------------------------------------------
// mask_lattice_and_outline_nodes_checker
// Watches the config port and both item channels, tracks the mask window and
// lattice phases on its own, and compares every result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mask_lattice_and_outline_nodes_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [mlon_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mlon_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              operation,
    input  logic                              inside_req,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              decided,
    input  logic                              is_node,
    input  logic [mlon_pkg::CELL_INDEX_W-1:0] cell_index,
    input  logic                              frame_done,
    output int                                fail_count,
    output int                                outstanding
);

    import mlon_pkg::*;

    localparam int RING_DEPTH = 2 * MAX_WIDTH + 4;

    typedef struct packed {
        logic                    decided;
        logic                    is_node;
        logic [CELL_INDEX_W-1:0] cell_index;
        logic                    frame_done;
    } node_decision_t;

    logic           mask_ring [RING_DEPTH];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] step_reg;
    int unsigned    arr_col;
    int unsigned    arr_row;
    int unsigned    col_phase;
    int unsigned    row_phase;
    int unsigned    decided_cells;
    int unsigned    dec_col;
    int unsigned    dec_row;
    node_decision_t decision_queue [$];

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return 32'(v);
    endfunction

    function void restart_frame();
        arr_col       = 0;
        arr_row       = 0;
        col_phase     = 0;
        row_phase     = 0;
        decided_cells = 0;
        dec_col       = 0;
        dec_row       = 0;
    endfunction

    function node_decision_t decide_next(int unsigned w, int unsigned h, int unsigned step);
        node_decision_t res;
        int             rr;
        int             cc;
        logic           center;
        logic           outline;
        logic           lattice_hit;
        logic           cell_bit;
        center  = 1'b0;
        outline = 1'b0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                rr = int'(dec_row) + dr;
                cc = int'(dec_col) + dc;
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
                begin
                    cell_bit = mask_ring[(rr * int'(w) + cc) % RING_DEPTH];
                    if (dr == 0 && dc == 0)
                    begin
                        center = cell_bit;
                    end
                    else if (!cell_bit)
                    begin
                        outline = 1'b1;
                    end
                end
            end
        end
        lattice_hit = (col_phase == 0 || dec_col == w - 1) && (row_phase == 0 || dec_row == h - 1);
        res.decided    = 1'b1;
        res.is_node    = center && (lattice_hit || outline);
        res.cell_index = CELL_INDEX_W'(decided_cells);
        res.frame_done = (decided_cells == w * h - 1);
        if (res.frame_done)
        begin
            restart_frame();
        end
        else
        begin
            decided_cells++;
            dec_col++;
            col_phase = (col_phase + 1 >= step) ? 0 : col_phase + 1;
            if (dec_col >= w)
            begin
                dec_col   = 0;
                col_phase = 0;
                dec_row++;
                row_phase = (row_phase + 1 >= step) ? 0 : row_phase + 1;
            end
        end
        return res;
    endfunction

    function node_decision_t predict_item(logic op, logic ins);
        node_decision_t res;
        int unsigned    w;
        int unsigned    h;
        int unsigned    step;
        int unsigned    total;
        int unsigned    received;
        res      = '0;
        w        = clamp_size(width_reg, MAX_WIDTH);
        h        = clamp_size(height_reg, MAX_HEIGHT);
        step     = (step_reg == 0) ? 1 : 32'(step_reg);
        total    = w * h;
        received = arr_row * w + arr_col;
        if (op == OP_CELL)
        begin
            if (received < total)
            begin
                mask_ring[received % RING_DEPTH] = ins;
                arr_col++;
                if (arr_col >= w)
                begin
                    arr_col = 0;
                    arr_row++;
                end
                received++;
                if (decided_cells + w + 1 < received)
                begin
                    res = decide_next(w, h, step);
                end
            end
        end
        else if (received >= total && decided_cells < total)
        begin
            res = decide_next(w, h, step);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        node_decision_t want;
        if (!rst_n)
        begin
            width_reg  = 11'd1024;
            height_reg = 11'd1024;
            step_reg   = 11'd1;
            restart_frame();
            decision_queue.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        width_reg = cfg_data;
                        restart_frame();
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        height_reg = cfg_data;
                        restart_frame();
                    end
                    REG_LATTICE_STEP:
                    begin
                        step_reg = cfg_data;
                        restart_frame();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
            begin
                decision_queue.push_back(predict_item(operation, inside_req));
            end
            if (out_valid && out_ready)
            begin
                if (decision_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: unexpected result item decided=%0b node=%0b idx=%0d done=%0b",
                                 $realtime, decided, is_node, cell_index, frame_done);
                    end
                end
                else
                begin
                    want = decision_queue.pop_front();
                    if (decided !== want.decided || is_node !== want.is_node ||
                        cell_index !== want.cell_index || frame_done !== want.frame_done)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch exp decided=%0b node=%0b idx=%0d done=%0b",
                                     $realtime, want.decided, want.is_node, want.cell_index,
                                     want.frame_done);
                            $display("%0t:          got decided=%0b node=%0b idx=%0d done=%0b",
                                     $realtime, decided, is_node, cell_index, frame_done);
                        end
                    end
                end
            end
            outstanding = decision_queue.size();
        end
    end

endmodule

/* tb/mask_lattice_and_outline_nodes_top_test.sv */
// ----------------------------------------------------------------------------
// mask_lattice_and_outline_nodes_top_test
// Drives mask frames, drain items and register writes into the node selector:
// a directed opening, a cut-short tallest frame, then random frames under three
// idling mixes with one long output stall each; the checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mask_lattice_and_outline_nodes_top_test;

    import mlon_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write_en;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    operation;
    logic                    inside_req;
    logic                    out_valid;
    logic                    out_ready;
    logic                    decided;
    logic                    is_node;
    logic [CELL_INDEX_W-1:0] cell_index;
    logic                    frame_done;

    int fail_count;
    int outstanding;
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_requests;
    int items_sent;

    mask_lattice_and_outline_nodes_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .inside_req   (inside_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .decided      (decided),
        .is_node      (is_node),
        .cell_index   (cell_index),
        .frame_done   (frame_done)
    );

    mask_lattice_and_outline_nodes_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .inside_req   (inside_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .decided      (decided),
        .is_node      (is_node),
        .cell_index   (cell_index),
        .frame_done   (frame_done),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver: random stalls, plus a long hold on request
    initial
    begin
        int served;
        int k;
        served = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != served)
            begin
                served = hold_requests;
                out_ready <= 1'b0;
                for (k = 1; k < 80; k++)
                begin
                    @(posedge clk);
                end
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    task automatic offer(input logic op, input logic ins);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        inside_req <= ins;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic load_frame(input int w, input int h, input int s);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_FRAME_WIDTH;
        cfg_data     <= CFG_W'(w);
        @(posedge clk);
        cfg_index    <= REG_FRAME_HEIGHT;
        cfg_data     <= CFG_W'(h);
        @(posedge clk);
        cfg_index    <= REG_LATTICE_STEP;
        cfg_data     <= CFG_W'(s);
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // cut_at >= 0 stops the frame after that many cells (restart follows)
    task automatic run_frame(input int w, input int h, input bit noisy, input int cut_at);
        int total;
        int pct;
        int i;
        total = w * h;
        pct   = $urandom_range(40, 100);
        for (i = 0; i < total; i++)
        begin
            if (i == cut_at)
            begin
                return;
            end
            if (noisy && $urandom_range(99) < 5)
            begin
                offer(OP_DRAIN, 1'($urandom_range(1)));
            end
            offer(OP_CELL, $urandom_range(99) < pct);
        end
        if (noisy && $urandom_range(1))
        begin
            offer(OP_CELL, 1'($urandom_range(1)));
        end
        for (i = 0; i < ((total < w + 1) ? total : w + 1); i++)
        begin
            offer(OP_DRAIN, 1'($urandom_range(1)));
        end
        if (noisy && $urandom_range(1))
        begin
            offer(OP_DRAIN, 1'b0);
        end
    endtask

    task automatic pick_frame(output int w, output int h, output int s);
        case ($urandom_range(9))
            0:
            begin
                w = $urandom_range(1, 3);
                h = $urandom_range(1, 30);
            end
            1:
            begin
                w = $urandom_range(20, 60);
                h = $urandom_range(1, 3);
            end
            default:
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 10);
            end
        endcase
        case ($urandom_range(5))
            0: s = 1;
            1: s = 1024;
            2: s = $urandom_range(1, 1024);
            default: s = $urandom_range(1, w + 1);
        endcase
    endtask

    task automatic random_frames(input int count);
        int goal;
        int w;
        int h;
        int s;
        int cut;
        goal = items_sent + count;
        settle();
        w = 8;
        h = 8;
        s = $urandom_range(1, 4);
        load_frame(w, h, s);
        hold_requests <= hold_requests + 1;
        while (items_sent < goal)
        begin
            cut = ($urandom_range(9) == 0) ? $urandom_range(w * h - 1) : -1;
            run_frame(w, h, $urandom_range(9) < 3, cut);
            if (cut >= 0 || $urandom_range(9) < 6)
            begin
                settle();
                pick_frame(w, h, s);
                load_frame(w, h, s);
            end
        end
    endtask

    initial
    begin
        logic [5:0] pattern;
        int         i;
        rst_n             <= 1'b0;
        cfg_write_en      <= 1'b0;
        cfg_index         <= REG_FRAME_WIDTH;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        operation         <= OP_CELL;
        inside_req        <= 1'b0;
        hold_requests     <= 0;
        sender_idle_pct   <= 14;
        receiver_idle_pct <= 66;
        items_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x2 frame: early drain, late cell, flush, drain with nothing pending
        load_frame(3, 2, 2);
        offer(OP_DRAIN, 1'b1);
        pattern = 6'b110111;
        for (i = 0; i < 6; i++)
        begin
            offer(OP_CELL, pattern[i]);
        end
        offer(OP_CELL, 1'b1);
        repeat (4) offer(OP_DRAIN, 1'b0);
        offer(OP_DRAIN, 1'b1);

        // single-cell frames, inside and outside
        settle();
        load_frame(1, 1, 1);
        offer(OP_CELL, 1'b1);
        offer(OP_DRAIN, 1'b0);
        offer(OP_CELL, 1'b0);
        offer(OP_DRAIN, 1'b1);

        // register write in the middle of a frame restarts it
        settle();
        load_frame(2, 2, 1);
        repeat (3) offer(OP_CELL, 1'b1);
        settle();
        load_frame(2, 1, 1);
        offer(OP_CELL, 1'b1);
        offer(OP_CELL, 1'b0);
        repeat (2) offer(OP_DRAIN, 1'b0);

        // tallest frame, cut short
        settle();
        load_frame(1, 1024, 7);
        run_frame(1, 1024, 1'b0, 150);

        random_frames(310);
        sender_idle_pct   <= 66;
        receiver_idle_pct <= 14;
        random_frames(310);
        sender_idle_pct   <= 0;
        receiver_idle_pct <= 0;
        random_frames(310);

        settle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
